### hw/rtl/rfr_pkg.sv
// rfr_pkg: types, constants and helpers shared by the radial/along/cross rotation block
// used by rfr_mac, rfr_sqdiv and rac_frame_rotation_top; no dependencies
package rfr_pkg;

    localparam int COORD_BITS     = 48;
    localparam int UNIT_FRAC_BITS = 30;
    localparam int ENTRY_BITS     = UNIT_FRAC_BITS + 2;
    localparam int HALF_BITS      = COORD_BITS / 2;
    localparam int MUL_BITS       = ENTRY_BITS + 1;
    localparam int PROD_BITS      = 2 * MUL_BITS;
    localparam int ACC_BITS       = 84;
    localparam int WIDE_BITS      = 64;
    localparam int ROOT_BITS      = 32;
    localparam int SQRT_ITER      = 32;
    localparam int DIV_ITER       = UNIT_FRAC_BITS + 1;
    localparam int CNT_BITS       = 6;

    // input transaction
    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] vec_x;
        logic signed [COORD_BITS-1:0] vec_y;
        logic signed [COORD_BITS-1:0] vec_z;
        logic signed [COORD_BITS-1:0] vel_x;
        logic signed [COORD_BITS-1:0] vel_y;
        logic signed [COORD_BITS-1:0] vel_z;
    } rfr_in_t;

    // result transaction
    typedef struct packed {
        logic signed [COORD_BITS-1:0] radial;
        logic signed [COORD_BITS-1:0] along_track;
        logic signed [COORD_BITS-1:0] cross_track;
        logic [1:0]                   status;
    } rfr_out_t;

    localparam logic ACT_BUILD  = 1'b0;
    localparam logic ACT_ROTATE = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_ZERO_POS   = 2'd1;
    localparam logic [1:0] STAT_ZERO_CROSS = 2'd2;
    localparam logic [1:0] STAT_NO_FRAME   = 2'd3;

    // one multiply-accumulate operation
    typedef struct packed {
        logic       clr;
        logic       sub;
        logic       hi;
        logic       last;
        logic       fin;
        logic [1:0] tag;
    } rfr_mac_op_t;

    typedef enum logic {SD_SQRT, SD_DIV} rfr_sd_mode_t;

    typedef struct packed {
        logic         start;
        rfr_sd_mode_t mode;
    } rfr_sd_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SC_R, ST_SC_V, ST_X1, ST_X1_W, ST_CHK_C, ST_SC_C, ST_X2, ST_X2_W,
        ST_LD_U, ST_SC_U, ST_SQ, ST_SQ_W, ST_SQRT_GO, ST_SQRT_W, ST_DIV_GO, ST_DIV_W,
        ST_ROT, ST_ROT_W, ST_DONE
    } rfr_state_t;

    // (i + d) mod 3 for indexes below 3
    function automatic logic [1:0] idx_add(input logic [1:0] i, input logic [1:0] d);
        logic [2:0] s;
        s = {1'b0, i} + {1'b0, d};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [WIDE_BITS-1:0] mag_coord(input logic signed [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] m;
        m = v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
        return WIDE_BITS'(m);
    endfunction

    function automatic logic [WIDE_BITS-1:0] mag_wide(input logic signed [WIDE_BITS-1:0] v);
        return v[WIDE_BITS-1] ? (~v + WIDE_BITS'(1)) : v;
    endfunction

    function automatic logic signed [ENTRY_BITS-1:0] apply_sign(input logic neg,
                                                               input logic [WIDE_BITS-1:0] m);
        logic signed [ENTRY_BITS-1:0] s;
        s = signed'(m[ENTRY_BITS-1:0]);
        return neg ? -s : s;
    endfunction

endpackage

### hw/rtl/rfr_mac.sv
// rfr_mac: shared two-stage signed multiplier with accumulator
// depends on rfr_pkg
module rfr_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 issue,
    input  rfr_pkg::rfr_mac_op_t                 op,
    input  logic signed [rfr_pkg::MUL_BITS-1:0]  opa,
    input  logic signed [rfr_pkg::MUL_BITS-1:0]  opb,
    output logic                                 res_valid,
    output rfr_pkg::rfr_mac_op_t                 res_op,
    output logic signed [rfr_pkg::ACC_BITS-1:0]  acc
);
    import rfr_pkg::*;

    logic                         v1_reg;
    rfr_mac_op_t                  op1_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic                         res_valid_reg;
    rfr_mac_op_t                  res_op_reg;
    logic signed [ACC_BITS-1:0]   term;
    logic signed [ACC_BITS-1:0]   ext;

    // product alignment and sign
    always_comb begin
        ext  = ACC_BITS'(prod_reg);
        term = op1_reg.hi ? (ext <<< HALF_BITS) : ext;
        if (op1_reg.sub) begin
            term = -term;
        end
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
        end
        op1_reg  <= op;
        prod_reg <= opa * opb;
    end

    // accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= v1_reg && op1_reg.last;
        end
        if (v1_reg) begin
            acc_reg    <= (op1_reg.clr ? '0 : acc_reg) + term;
            res_op_reg <= op1_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_op    = res_op_reg;
    assign acc       = acc_reg;

endmodule

### hw/rtl/rfr_sqdiv.sv
// rfr_sqdiv: iterative integer square root and fraction divider, one bit per cycle
// depends on rfr_pkg
module rfr_sqdiv (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rfr_pkg::rfr_sd_cmd_t               cmd,
    input  logic [rfr_pkg::WIDE_BITS-1:0]      rad,
    input  logic [rfr_pkg::ROOT_BITS-1:0]      num,
    input  logic [rfr_pkg::ROOT_BITS-1:0]      den,
    output logic                               done,
    output logic [rfr_pkg::ROOT_BITS-1:0]      result
);
    import rfr_pkg::*;

    localparam logic [WIDE_BITS-1:0] BIT_START = WIDE_BITS'(1) << (WIDE_BITS - 2);

    logic                  busy_reg;
    logic                  done_reg;
    rfr_sd_mode_t          mode_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [WIDE_BITS-1:0]  x_reg;
    logic [WIDE_BITS-1:0]  res_reg;
    logic [WIDE_BITS-1:0]  bit_reg;
    logic [ROOT_BITS:0]    rem_reg;
    logic [ROOT_BITS-1:0]  q_reg;
    logic [WIDE_BITS-1:0]  trial;
    logic [ROOT_BITS:0]    rem_sh;
    logic [ROOT_BITS:0]    q_inc;

    assign trial  = res_reg + bit_reg;
    assign rem_sh = {rem_reg[ROOT_BITS-1:0], 1'b0};
    assign q_inc  = {1'b0, q_reg} + (ROOT_BITS+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.mode;
                if (cmd.mode == SD_SQRT) begin
                    cnt_reg <= CNT_BITS'(SQRT_ITER - 1);
                    x_reg   <= rad;
                    res_reg <= '0;
                    bit_reg <= BIT_START;
                end else begin
                    cnt_reg <= CNT_BITS'(DIV_ITER - 1);
                    q_reg   <= ROOT_BITS'(num >= den);
                    rem_reg <= (num >= den) ? {1'b0, num - den} : {1'b0, num};
                end
            end else if (busy_reg) begin
                // one root bit or one quotient bit
                if (mode_reg == SD_SQRT) begin
                    if (x_reg >= trial) begin
                        x_reg   <= x_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end else begin
                    if (rem_sh >= {1'b0, den}) begin
                        rem_reg <= rem_sh - {1'b0, den};
                        q_reg   <= {q_reg[ROOT_BITS-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        q_reg   <= {q_reg[ROOT_BITS-2:0], 1'b0};
                    end
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - CNT_BITS'(1);
                end
            end
        end
    end

    // root, or quotient rounded half up
    assign result = (mode_reg == SD_SQRT) ? res_reg[ROOT_BITS-1:0] : q_inc[ROOT_BITS:1];
    assign done   = done_reg;

endmodule

### hw/rtl/rac_frame_rotation_top.sv
// rac_frame_rotation_top: builds and applies a radial/along/cross-track rotation
// depends on rfr_pkg, rfr_mac and rfr_sqdiv
//
// Usage
//   s_ channel (valid/ready) carries one transaction: action 0 builds the frame from
//   position vec_* and velocity vel_*, action 1 rotates vec_* into the stored frame.
//   m_ channel (valid/ready) returns exactly one result per input transaction.
//   The block takes one transaction at a time; s_ready is high only while idle.
//   Rotate: 18 products through the shared multiplier.
//   Build: block scaling shifts one bit a cycle per vector (six vectors), then three
//   square roots and nine divisions in the shared root/divide unit; the total time
//   depends on the magnitudes.
//   Errors (zero position, zero cross product, rotate with no frame) finish early with status set.
//   Reset clears the frame (entries zero, frame invalid) and empties the output.
//   A stalled receiver holds the result in the output register; the next input
//   is accepted meanwhile and its result waits until the register frees.
module rac_frame_rotation_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rfr_pkg::rfr_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output rfr_pkg::rfr_out_t m_payload
);
    import rfr_pkg::*;

    localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [ACC_BITS-1:0]   RND_HALF = ACC_BITS'(1) << (UNIT_FRAC_BITS - 1);

    rfr_state_t                    state_reg, state_next;
    rfr_in_t                       item_reg;
    rfr_out_t                      out_reg;
    logic                          m_valid_reg;
    logic                          frame_valid_reg;
    logic signed [ENTRY_BITS-1:0]  entry_reg [9];
    logic signed [ENTRY_BITS-1:0]  r30_reg [3];
    logic signed [ENTRY_BITS-1:0]  v30_reg [3];
    logic signed [ENTRY_BITS-1:0]  c30_reg [3];
    logic signed [WIDE_BITS-1:0]   c_reg [3];
    logic signed [WIDE_BITS-1:0]   a_reg [3];
    logic [WIDE_BITS-1:0]          sc_mag_reg [3];
    logic                          sc_neg_reg [3];
    logic signed [COORD_BITS-1:0]  rot_reg [3];
    logic [1:0]                    status_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic [1:0]                    unit_reg;
    logic [1:0]                    row_reg;
    logic [1:0]                    col_reg;
    logic                          half_reg;
    logic [WIDE_BITS-1:0]          sum_reg;
    logic [ROOT_BITS-1:0]          norm_reg;

    logic                          issue;
    rfr_mac_op_t                   op;
    logic signed [MUL_BITS-1:0]    opa, opb;
    logic                          mac_valid;
    rfr_mac_op_t                   mac_op;
    logic signed [ACC_BITS-1:0]    mac_acc;
    rfr_sd_cmd_t                   sd_cmd;
    logic                          sd_done;
    logic [ROOT_BITS-1:0]          sd_result;

    logic                          out_load;
    logic [WIDE_BITS-1:0]          sc_or;
    logic                          sc_top31;
    logic                          sc_big, sc_low, sc_done;
    logic signed [COORD_BITS-1:0]  ivec [3];
    logic signed [COORD_BITS-1:0]  ivel [3];
    logic signed [COORD_BITS-1:0]  svec [3];
    logic [WIDE_BITS-1:0]          src_mag [3];
    logic                          src_neg [3];
    logic                          src_zero;
    logic                          c_zero;
    logic [1:0]                    k_idx, ia, ib;
    logic [3:0]                    rot_idx, ent_idx;
    logic signed [ACC_BITS-1:0]    rnd;
    logic signed [ACC_BITS-1:0]    shr;
    logic                          ovf;
    logic signed [COORD_BITS-1:0]  sat_val;

    rfr_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .op        (op),
        .opa       (opa),
        .opb       (opb),
        .res_valid (mac_valid),
        .res_op    (mac_op),
        .acc       (mac_acc)
    );

    rfr_sqdiv u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (sd_cmd),
        .rad     (sum_reg),
        .num     (sc_mag_reg[cnt_reg[1:0]][ROOT_BITS-1:0]),
        .den     (norm_reg),
        .done    (sd_done),
        .result  (sd_result)
    );

    // field views
    assign ivec[0] = item_reg.vec_x;
    assign ivec[1] = item_reg.vec_y;
    assign ivec[2] = item_reg.vec_z;
    assign ivel[0] = item_reg.vel_x;
    assign ivel[1] = item_reg.vel_y;
    assign ivel[2] = item_reg.vel_z;
    assign svec[0] = s_payload.vec_x;
    assign svec[1] = s_payload.vec_y;
    assign svec[2] = s_payload.vec_z;

    // block scaler range check
    always_comb begin
        sc_or    = sc_mag_reg[0] | sc_mag_reg[1] | sc_mag_reg[2];
        sc_top31 = (state_reg == ST_SC_U);
        if (sc_top31) begin
            sc_big = |sc_or[WIDE_BITS-1:UNIT_FRAC_BITS+1];
            sc_low = ~|sc_or[WIDE_BITS-1:UNIT_FRAC_BITS];
        end else begin
            sc_big = |sc_or[WIDE_BITS-1:UNIT_FRAC_BITS];
            sc_low = ~|sc_or[WIDE_BITS-1:UNIT_FRAC_BITS-1];
        end
        sc_done = (sc_or == '0) || (!sc_big && !sc_low);
    end

    // source vector for the next unit row
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            unique case (unit_reg)
                2'd0: begin
                    src_mag[i] = mag_coord(ivec[i]);
                    src_neg[i] = ivec[i][COORD_BITS-1];
                end
                2'd1: begin
                    src_mag[i] = mag_wide(a_reg[i]);
                    src_neg[i] = a_reg[i][WIDE_BITS-1];
                end
                default: begin
                    src_mag[i] = mag_wide(c_reg[i]);
                    src_neg[i] = c_reg[i][WIDE_BITS-1];
                end
            endcase
        end
        src_zero = (src_mag[0] | src_mag[1] | src_mag[2]) == '0;
        c_zero   = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
    end

    // index arithmetic
    always_comb begin
        k_idx   = cnt_reg[2:1];
        ia      = cnt_reg[0] ? idx_add(k_idx, 2'd2) : idx_add(k_idx, 2'd1);
        ib      = cnt_reg[0] ? idx_add(k_idx, 2'd1) : idx_add(k_idx, 2'd2);
        rot_idx = {row_reg, 2'b00} - {2'b00, row_reg} + {2'b00, col_reg};
        ent_idx = {unit_reg, 2'b00} - {2'b00, unit_reg} + {2'b00, cnt_reg[1:0]};
    end

    // rounding and saturation of a rotated component
    always_comb begin
        rnd     = mac_acc + RND_HALF;
        shr     = rnd >>> UNIT_FRAC_BITS;
        ovf     = !((&shr[ACC_BITS-1:COORD_BITS-1]) || (~|shr[ACC_BITS-1:COORD_BITS-1]));
        sat_val = ovf ? (shr[ACC_BITS-1] ? SAT_MIN : SAT_MAX) : shr[COORD_BITS-1:0];
    end

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_payload.action == ACT_ROTATE) begin
                        state_next = frame_valid_reg ? ST_ROT : ST_DONE;
                    end else if ((svec[0] | svec[1] | svec[2]) == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SC_R;
                    end
                end
            end
            ST_SC_R:    if (sc_done) state_next = ST_SC_V;
            ST_SC_V:    if (sc_done) state_next = ST_X1;
            ST_X1:      if (cnt_reg == CNT_BITS'(5)) state_next = ST_X1_W;
            ST_X1_W:    if (mac_valid && mac_op.fin) state_next = ST_CHK_C;
            ST_CHK_C:   state_next = c_zero ? ST_DONE : ST_SC_C;
            ST_SC_C:    if (sc_done) state_next = ST_X2;
            ST_X2:      if (cnt_reg == CNT_BITS'(5)) state_next = ST_X2_W;
            ST_X2_W:    if (mac_valid && mac_op.fin) state_next = ST_LD_U;
            ST_LD_U:    state_next = src_zero ? ST_DONE : ST_SC_U;
            ST_SC_U:    if (sc_done) state_next = ST_SQ;
            ST_SQ:      if (cnt_reg == CNT_BITS'(2)) state_next = ST_SQ_W;
            ST_SQ_W:    if (mac_valid && mac_op.fin) state_next = ST_SQRT_GO;
            ST_SQRT_GO: state_next = ST_SQRT_W;
            ST_SQRT_W:  if (sd_done) state_next = ST_DIV_GO;
            ST_DIV_GO:  state_next = ST_DIV_W;
            ST_DIV_W: begin
                if (sd_done) begin
                    if (cnt_reg[1:0] != 2'd2) begin
                        state_next = ST_DIV_GO;
                    end else begin
                        state_next = (unit_reg == 2'd2) ? ST_DONE : ST_LD_U;
                    end
                end
            end
            ST_ROT: begin
                if (row_reg == 2'd2 && col_reg == 2'd2 && half_reg) state_next = ST_ROT_W;
            end
            ST_ROT_W:   if (mac_valid && mac_op.fin) state_next = ST_DONE;
            ST_DONE:    if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready    = (state_reg == ST_IDLE);
        issue      = 1'b0;
        op         = '0;
        opa        = '0;
        opb        = '0;
        sd_cmd     = '{start: 1'b0, mode: SD_SQRT};
        unique case (state_reg)
            ST_X1, ST_X2: begin
                issue   = 1'b1;
                op.clr  = !cnt_reg[0];
                op.sub  = cnt_reg[0];
                op.last = cnt_reg[0];
                op.fin  = (cnt_reg == CNT_BITS'(5));
                op.tag  = k_idx;
                if (state_reg == ST_X1) begin
                    opa = MUL_BITS'(r30_reg[ia]);
                    opb = MUL_BITS'(v30_reg[ib]);
                end else begin
                    opa = MUL_BITS'(c30_reg[ia]);
                    opb = MUL_BITS'(r30_reg[ib]);
                end
            end
            ST_SQ: begin
                issue   = 1'b1;
                op.clr  = (cnt_reg == '0);
                op.last = (cnt_reg == CNT_BITS'(2));
                op.fin  = (cnt_reg == CNT_BITS'(2));
                opa     = signed'({1'b0, sc_mag_reg[cnt_reg[1:0]][ENTRY_BITS-1:0]});
                opb     = opa;
            end
            ST_ROT: begin
                issue   = 1'b1;
                op.clr  = (col_reg == 2'd0) && !half_reg;
                op.last = (col_reg == 2'd2) && half_reg;
                op.fin  = (col_reg == 2'd2) && half_reg && (row_reg == 2'd2);
                op.hi   = half_reg;
                op.tag  = row_reg;
                opa     = MUL_BITS'(entry_reg[rot_idx]);
                if (half_reg) begin
                    opb = MUL_BITS'(signed'(ivec[col_reg][COORD_BITS-1:HALF_BITS]));
                end else begin
                    opb = signed'(MUL_BITS'(ivec[col_reg][HALF_BITS-1:0]));
                end
            end
            ST_SQRT_GO: sd_cmd = '{start: 1'b1, mode: SD_SQRT};
            ST_DIV_GO:  sd_cmd = '{start: 1'b1, mode: SD_DIV};
            default: ;
        endcase
    end

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            frame_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) entry_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg   <= s_payload;
                        status_reg <= STAT_OK;
                        for (int i = 0; i < 3; i++) begin
                            rot_reg[i]    <= '0;
                            sc_mag_reg[i] <= mag_coord(svec[i]);
                            sc_neg_reg[i] <= svec[i][COORD_BITS-1];
                        end
                        row_reg  <= '0;
                        col_reg  <= '0;
                        half_reg <= 1'b0;
                        unit_reg <= '0;
                        if (s_payload.action == ACT_ROTATE) begin
                            if (!frame_valid_reg) status_reg <= STAT_NO_FRAME;
                        end else begin
                            frame_valid_reg <= 1'b0;
                            for (int i = 0; i < 9; i++) entry_reg[i] <= '0;
                            if ((svec[0] | svec[1] | svec[2]) == '0) begin
                                status_reg <= STAT_ZERO_POS;
                            end
                        end
                    end
                end
                ST_SC_R, ST_SC_V, ST_SC_C, ST_SC_U: begin
                    if (sc_done) begin
                        cnt_reg <= '0;
                        for (int i = 0; i < 3; i++) begin
                            if (state_reg == ST_SC_R) begin
                                r30_reg[i]    <= apply_sign(sc_neg_reg[i], sc_mag_reg[i]);
                                sc_mag_reg[i] <= mag_coord(ivel[i]);
                                sc_neg_reg[i] <= ivel[i][COORD_BITS-1];
                            end else if (state_reg == ST_SC_V) begin
                                v30_reg[i] <= apply_sign(sc_neg_reg[i], sc_mag_reg[i]);
                            end else if (state_reg == ST_SC_C) begin
                                c30_reg[i] <= apply_sign(sc_neg_reg[i], sc_mag_reg[i]);
                            end
                        end
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            sc_mag_reg[i] <= sc_big ? (sc_mag_reg[i] >> 1) : (sc_mag_reg[i] << 1);
                        end
                    end
                end
                ST_X1, ST_X2, ST_SQ: cnt_reg <= cnt_reg + CNT_BITS'(1);
                ST_CHK_C: begin
                    if (c_zero) begin
                        status_reg <= STAT_ZERO_CROSS;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            sc_mag_reg[i] <= mag_wide(c_reg[i]);
                            sc_neg_reg[i] <= c_reg[i][WIDE_BITS-1];
                        end
                    end
                end
                ST_LD_U: begin
                    if (src_zero) begin
                        status_reg <= STAT_ZERO_CROSS;
                        for (int i = 0; i < 9; i++) entry_reg[i] <= '0;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            sc_mag_reg[i] <= src_mag[i];
                            sc_neg_reg[i] <= src_neg[i];
                        end
                    end
                end
                ST_SQ_W: if (mac_valid) sum_reg <= mac_acc[WIDE_BITS-1:0];
                ST_SQRT_W: begin
                    if (sd_done) begin
                        norm_reg <= sd_result;
                        cnt_reg  <= '0;
                    end
                end
                ST_DIV_W: begin
                    if (sd_done) begin
                        entry_reg[ent_idx] <= apply_sign(sc_neg_reg[cnt_reg[1:0]],
                                                         WIDE_BITS'(sd_result));
                        if (cnt_reg[1:0] != 2'd2) begin
                            cnt_reg <= cnt_reg + CNT_BITS'(1);
                        end else if (unit_reg == 2'd2) begin
                            frame_valid_reg <= 1'b1;
                        end else begin
                            unit_reg <= unit_reg + 2'd1;
                        end
                    end
                end
                ST_ROT: begin
                    half_reg <= !half_reg;
                    if (half_reg) begin
                        if (col_reg == 2'd2) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 2'd1;
                        end else begin
                            col_reg <= col_reg + 2'd1;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_load) begin
                        out_reg.radial      <= rot_reg[0];
                        out_reg.along_track <= rot_reg[1];
                        out_reg.cross_track <= rot_reg[2];
                        out_reg.status      <= status_reg;
                    end
                end
                default: ;
            endcase

            // multiplier results, some of which arrive while products are still being issued
            if (mac_valid) begin
                if (state_reg == ST_X1 || state_reg == ST_X1_W) begin
                    c_reg[mac_op.tag] <= mac_acc[WIDE_BITS-1:0];
                end else if (state_reg == ST_X2 || state_reg == ST_X2_W) begin
                    a_reg[mac_op.tag] <= mac_acc[WIDE_BITS-1:0];
                end else if (state_reg == ST_ROT || state_reg == ST_ROT_W) begin
                    rot_reg[mac_op.tag] <= sat_val;
                end
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

`ifndef SYNTHESIS
    // busy from the cycle after a transaction is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while still working");

    // error results carry no components
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != STAT_OK |->
            m_payload.radial == '0 && m_payload.along_track == '0 &&
            m_payload.cross_track == '0)
        else $error("error result with nonzero components");

    // a valid frame has a nonzero radial row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_valid_reg |-> (entry_reg[0] != '0 || entry_reg[1] != '0 || entry_reg[2] != '0))
        else $error("valid frame with zero radial row");
`endif

endmodule
